[rtl/bcem_pkg.sv]
// ----------------------------------------------------------------------------
// bcem_pkg
// Shared widths, constants, types and helpers of the mean binary
// cross-entropy core.
// ----------------------------------------------------------------------------
package bcem_pkg;

  // Fixed-point format of labels and predictions (Q1.FRAC_BITS)
  localparam int FRAC_BITS = 16;
  localparam int LABEL_W   = FRAC_BITS + 1;
  localparam int FX_W      = FRAC_BITS;
  localparam int EXP_W     = $clog2(FX_W);

  // Log unit: fraction bits of log2 and width of a -ln result
  localparam int LOG_BITS  = 24;
  localparam int LN_W      = 20;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Accumulator, divisor and mean widths
  localparam int SUM_W     = 40;
  localparam int ROW_W     = 16;
  localparam int MEAN_W    = 20;

  // Stream bus widths (fields packed from bit 0, padded to bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // Default depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic [LABEL_W-1:0] label;   // clamped to one
    logic [FX_W-1:0]    pos_x;   // prediction, clipped to 1..ONE-1
    logic [FX_W-1:0]    neg_x;   // ONE - prediction, 1..ONE-1
    logic               last;
  } bcem_item_t;

  // One result of the block
  typedef struct packed {
    logic [MEAN_W-1:0] mean_loss;
    logic              saturated;
  } bcem_result_t;

  // Index of the highest set bit (zero when no bit is set)
  function automatic logic [EXP_W-1:0] msb_index(input logic [FX_W-1:0] x);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FX_W; i++) begin
      if (x[i]) begin
        idx = EXP_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/bcem_front.sv]
// ----------------------------------------------------------------------------
// bcem_front
// Input stage: accepts label/prediction pairs, clips them into the legal
// range and registers the classified item for the queue.
// ----------------------------------------------------------------------------
module bcem_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bcem_pkg::LABEL_W-1:0] label_i,
  input  logic [bcem_pkg::LABEL_W-1:0] prediction_i,
  input  logic                         last_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output bcem_pkg::bcem_item_t         item_o
);
  import bcem_pkg::*;

  localparam logic [LABEL_W-1:0] ONE_FX = LABEL_W'(1) << FRAC_BITS;

  logic               vld_q;
  bcem_item_t         item_q;
  bcem_item_t         item_d;
  logic [LABEL_W-1:0] pred_clip;
  logic [LABEL_W-1:0] pred_neg;

  // Clip label to one, prediction into 1..ONE-1
  always_comb begin
    if (prediction_i == '0) begin
      pred_clip = LABEL_W'(1);
    end else if (prediction_i >= ONE_FX) begin
      pred_clip = ONE_FX - LABEL_W'(1);
    end else begin
      pred_clip = prediction_i;
    end
    pred_neg      = ONE_FX - pred_clip;
    item_d.label  = (label_i > ONE_FX) ? ONE_FX : label_i;
    item_d.pos_x  = pred_clip[FX_W-1:0];
    item_d.neg_x  = pred_neg[FX_W-1:0];
    item_d.last   = last_i;
  end

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  // Hold one classified item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      item_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q  <= 1'b1;
      item_q <= item_d;
    end else if (item_ready_i) begin
      vld_q  <= 1'b0;
    end
  end

endmodule

[rtl/bcem_fifo.sv]
// ----------------------------------------------------------------------------
// bcem_fifo
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module bcem_fifo #(
  parameter int DEPTH = bcem_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  bcem_pkg::bcem_item_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output bcem_pkg::bcem_item_t pop_data_o
);
  import bcem_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcem_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q < CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/bcem_nlog.sv]
// ----------------------------------------------------------------------------
// bcem_nlog
// Iterative -ln(x/ONE) unit: normalizes x, extracts LOG_BITS fraction bits
// of log2 by repeated squaring (one per cycle), then scales by ln 2.
// ----------------------------------------------------------------------------
module bcem_nlog (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bcem_pkg::FX_W-1:0] x_i,
  output logic                      done_o,
  output logic [bcem_pkg::LN_W-1:0] result_o
);
  import bcem_pkg::*;

  localparam int K_W   = EXP_W + 1;
  localparam int N_W   = K_W + LOG_BITS;
  localparam int P_W   = N_W + 32;
  localparam int SH    = 56 - FRAC_BITS;
  localparam int CNT_W = $clog2(LOG_BITS);

  typedef enum logic [1:0] {LG_IDLE, LG_SQUARE, LG_SCALE, LG_ROUND} state_e;

  state_e              state_q;
  logic [31:0]         z_q;
  logic [LOG_BITS-1:0] f_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [K_W-1:0]      k_q;
  logic [P_W-1:0]      prod_q;
  logic                done_q;
  logic [LN_W-1:0]     result_q;

  logic [EXP_W-1:0]    e_load;
  logic [63:0]         sq;
  logic [32:0]         z_sq;
  logic [N_W-1:0]      n_val;
  logic [P_W-1:0]      round_sum;

  always_comb begin
    e_load    = msb_index(x_i);
    sq        = z_q * z_q;
    z_sq      = sq[63:31];
    n_val     = {k_q, {LOG_BITS{1'b0}}} - N_W'(f_q);
    round_sum = prod_q + (P_W'(1) << (SH - 1));
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Sequence normalize, square steps, scale and round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LG_IDLE;
      z_q      <= '0;
      f_q      <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      prod_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= (state_q == LG_ROUND);
      case (state_q)
        LG_IDLE: begin
          if (start_i) begin
            z_q     <= 32'(x_i) << (5'd31 - 5'(e_load));
            k_q     <= K_W'(FRAC_BITS) - K_W'(e_load);
            f_q     <= '0;
            cnt_q   <= '0;
            state_q <= LG_SQUARE;
          end
        end
        LG_SQUARE: begin
          // Square the mantissa, renormalize and shift in one bit of log2
          if (z_sq[32]) begin
            z_q <= z_sq[32:1];
          end else begin
            z_q <= z_sq[31:0];
          end
          f_q   <= {f_q[LOG_BITS-2:0], z_sq[32]};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(LOG_BITS - 1)) begin
            state_q <= LG_SCALE;
          end
        end
        LG_SCALE: begin
          prod_q  <= P_W'(n_val) * P_W'(LN2_Q32);
          state_q <= LG_ROUND;
        end
        LG_ROUND: begin
          result_q <= round_sum[SH +: LN_W];
          state_q  <= LG_IDLE;
        end
        default: begin
          state_q <= LG_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bcem_div.sv]
// ----------------------------------------------------------------------------
// bcem_div
// Mean divider: checks for an out-of-range quotient, else runs a restoring
// division that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcem_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bcem_pkg::SUM_W-1:0] dividend_i,
  input  logic [bcem_pkg::ROW_W-1:0] divisor_i,
  output logic                       done_o,
  output bcem_pkg::bcem_result_t     result_o
);
  import bcem_pkg::*;

  localparam int HI_W  = SUM_W - MEAN_W;
  localparam int CNT_W = $clog2(MEAN_W);

  typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_STEP} state_e;

  state_e            state_q;
  logic [SUM_W-1:0]  num_q;
  logic [ROW_W-1:0]  div_q;
  logic [ROW_W-1:0]  rem_q;
  logic [MEAN_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  bcem_result_t      result_q;

  logic [ROW_W:0]    rem_shift;
  logic [ROW_W:0]    rem_diff;
  logic              rem_ge;
  logic [MEAN_W-1:0] quo_next;
  logic              over_range;
  logic              last_step;

  always_comb begin
    rem_shift  = {rem_q, quo_q[MEAN_W-1]};
    rem_diff   = rem_shift - {1'b0, div_q};
    rem_ge     = rem_shift >= {1'b0, div_q};
    quo_next   = {quo_q[MEAN_W-2:0], rem_ge};
    // Quotient reaches 2^MEAN_W exactly when the upper part >= divisor
    over_range = num_q[SUM_W-1:MEAN_W] >= HI_W'(div_q);
    last_step  = cnt_q == CNT_W'(MEAN_W - 1);
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Check range, then shift-subtract one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DV_IDLE;
      num_q    <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= ((state_q == DV_CHECK) && over_range)
             || ((state_q == DV_STEP) && last_step);
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            num_q   <= dividend_i;
            div_q   <= (divisor_i == '0) ? ROW_W'(1) : divisor_i;
            state_q <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          if (over_range) begin
            result_q.mean_loss <= '1;
            result_q.saturated <= 1'b1;
            state_q            <= DV_IDLE;
          end else begin
            rem_q   <= num_q[MEAN_W +: ROW_W];
            quo_q   <= num_q[MEAN_W-1:0];
            cnt_q   <= '0;
            state_q <= DV_STEP;
          end
        end
        DV_STEP: begin
          rem_q <= rem_ge ? rem_diff[ROW_W-1:0] : rem_shift[ROW_W-1:0];
          quo_q <= quo_next;
          cnt_q <= cnt_q + CNT_W'(1);
          if (last_step) begin
            result_q.mean_loss <= quo_next;
            result_q.saturated <= 1'b0;
            state_q            <= DV_IDLE;
          end
        end
        default: begin
          state_q <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bcem_back.sv]
// ----------------------------------------------------------------------------
// bcem_back
// Execution stage: takes one classified item from the queue, evaluates both
// logarithms, weights and accumulates the loss, and on the last item of a
// batch divides by the row count into the output register.
// ----------------------------------------------------------------------------
module bcem_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  bcem_pkg::bcem_item_t       item_i,
  input  logic [bcem_pkg::ROW_W-1:0] row_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bcem_pkg::bcem_result_t     out_o
);
  import bcem_pkg::*;

  localparam logic [LABEL_W-1:0] ONE_FX = LABEL_W'(1) << FRAC_BITS;
  localparam int PROD_W = LABEL_W + LN_W;
  localparam int TSUM_W = PROD_W + 1;
  localparam int TERM_W = TSUM_W - FRAC_BITS;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOG, BK_MUL, BK_TERM, BK_ACC, BK_DIV, BK_OUT
  } state_e;

  state_e             state_q;
  bcem_item_t         item_q;
  logic [PROD_W-1:0]  pos_prod_q;
  logic [PROD_W-1:0]  neg_prod_q;
  logic [TERM_W-1:0]  term_q;
  logic [SUM_W-1:0]   sum_q;
  logic               out_vld_q;
  bcem_result_t       out_q;

  logic               lane_start;
  logic               pos_done;
  logic               neg_done;
  logic [LN_W-1:0]    pos_ln;
  logic [LN_W-1:0]    neg_ln;
  logic [LABEL_W-1:0] neg_wgt;
  logic [TSUM_W-1:0]  term_sum;
  logic [SUM_W:0]     acc;
  logic [SUM_W-1:0]   sum_next;
  logic               div_start;
  logic               div_done;
  bcem_result_t       div_res;

  assign item_ready_o = state_q == BK_IDLE;
  assign lane_start   = item_valid_i && item_ready_o;
  assign div_start    = (state_q == BK_ACC) && item_q.last;
  assign out_valid_o  = out_vld_q;
  assign out_o        = out_q;

  // Log lanes for p and 1-p run side by side
  bcem_nlog u_nlog_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .x_i      (item_i.pos_x),
    .done_o   (pos_done),
    .result_o (pos_ln)
  );

  bcem_nlog u_nlog_neg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .x_i      (item_i.neg_x),
    .done_o   (neg_done),
    .result_o (neg_ln)
  );

  bcem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_next),
    .divisor_i  (row_count_i),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  // Round the weighted sum, saturate the running total
  always_comb begin
    neg_wgt  = ONE_FX - item_q.label;
    term_sum = TSUM_W'(pos_prod_q) + TSUM_W'(neg_prod_q)
             + (TSUM_W'(1) << (FRAC_BITS - 1));
    acc      = {1'b0, sum_q} + (SUM_W + 1)'(term_q);
    sum_next = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
  end

  // Sequence one item, hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      item_q     <= '0;
      pos_prod_q <= '0;
      neg_prod_q <= '0;
      term_q     <= '0;
      sum_q      <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (out_vld_q && out_ready_i && (state_q != BK_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (lane_start) begin
            item_q  <= item_i;
            state_q <= BK_LOG;
          end
        end
        BK_LOG: begin
          if (pos_done && neg_done) begin
            state_q <= BK_MUL;
          end
        end
        BK_MUL: begin
          pos_prod_q <= PROD_W'(item_q.label) * PROD_W'(pos_ln);
          neg_prod_q <= PROD_W'(neg_wgt) * PROD_W'(neg_ln);
          state_q    <= BK_TERM;
        end
        BK_TERM: begin
          term_q  <= term_sum[FRAC_BITS +: TERM_W];
          state_q <= BK_ACC;
        end
        BK_ACC: begin
          // Last item: hand the total to the divider and clear it
          if (item_q.last) begin
            sum_q   <= '0;
            state_q <= BK_DIV;
          end else begin
            sum_q   <= sum_next;
            state_q <= BK_IDLE;
          end
        end
        BK_DIV: begin
          if (div_done) begin
            state_q <= BK_OUT;
          end
        end
        BK_OUT: begin
          if (!out_vld_q || out_ready_i) begin
            out_q     <= div_res;
            out_vld_q <= 1'b1;
            state_q   <= BK_IDLE;
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/binary_cross_entropy_mean_core.sv]
// ----------------------------------------------------------------------------
// binary_cross_entropy_mean_core
// Mean binary cross-entropy loss over a stream of label/prediction pairs.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream carries one Q1.16 label/prediction pair;
// tlast closes a batch. A transfer that is not last produces nothing; the
// last one produces one master transfer with the accumulated loss divided by
// row_count in Q4.16 (tuser set when the mean was clamped). Predictions of
// 0 and 1 are pulled in by one LSB, labels above 1 are taken as 1, and a
// row_count of 0 acts as 1. Each item occupies the back end for the 24
// squaring steps of the two log units that run side by side plus scaling,
// weighting and accumulation; the last item of a batch adds the bit-serial
// divider. The front register and the QUEUE_DEPTH-entry queue accept items
// ahead of the back end, and a finished result waits in its own output
// register. Write row_count only while no batch is in flight.
// ----------------------------------------------------------------------------
module binary_cross_entropy_mean_core #(
  parameter int QUEUE_DEPTH = bcem_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: label [16:0], prediction [33:17], zero padding [39:34]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bcem_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,
  // tdata: mean_loss [19:0], zero padding [23:20]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bcem_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // tuser: saturated [0]
  output logic                           m_axis_tuser,
  // row_count write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcem_pkg::ROW_W-1:0]     cfg_data_i
);
  import bcem_pkg::*;

  logic [ROW_W-1:0] row_count_q;
  logic             q_push_valid;
  logic             q_push_ready;
  bcem_item_t       q_push_data;
  logic             q_pop_valid;
  logic             q_pop_ready;
  bcem_item_t       q_pop_data;
  bcem_result_t     result;

  // Row count register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_count_q <= cfg_data_i;
    end
  end

  bcem_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .label_i      (s_axis_tdata[LABEL_W-1:0]),
    .prediction_i (s_axis_tdata[2*LABEL_W-1:LABEL_W]),
    .last_i       (s_axis_tlast),
    .item_valid_o (q_push_valid),
    .item_ready_i (q_push_ready),
    .item_o       (q_push_data)
  );

  bcem_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  bcem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_pop_valid),
    .item_ready_o (q_pop_ready),
    .item_i       (q_pop_data),
    .row_count_i  (row_count_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  assign m_axis_tdata = {{(M_TDATA_W - MEAN_W){1'b0}}, result.mean_loss};
  assign m_axis_tuser = result.saturated;

endmodule

[rtl/bcem_checker.sv]
// ----------------------------------------------------------------------------
// bcem_checker
// Port-level checks of the result stream, bound to the core.
// ----------------------------------------------------------------------------
module bcem_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bcem_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import bcem_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A clamped mean reads as full scale
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[MEAN_W-1:0] == {MEAN_W{1'b1}})
    else $error("saturated flag without full-scale mean");

  // Padding above the mean stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:MEAN_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind binary_cross_entropy_mean_core bcem_checker u_bcem_checker (.*);
